/* sv/autocrop_bounding_box_assert.svh */
// Assertion macros used by the checker file of the autocrop block.
`ifndef AUTOCROP_BOUNDING_BOX_ASSERT_SVH
`define AUTOCROP_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/acb_pkg.sv */
// ----------------------------------------------------------------------------
// acb_pkg
// Types, sizes and helper functions shared by the autocrop bounding box block.
// ----------------------------------------------------------------------------
package acb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_W    = 32;
    localparam int SIZE_W     = 13;
    localparam int COORD_W    = 12;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // One classified pixel passed from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               diff;
        logic               last;
    } t_entry;

    // Effective frame size after clamping.
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_frame_size;

    // A zero size acts as one, anything above the maximum acts as the maximum.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* sv/autocrop_bounding_box.sv */
// ----------------------------------------------------------------------------
// autocrop_bounding_box
// Finds the bounding box of the content that differs from the background.
// ----------------------------------------------------------------------------
// Usage: pixels of one frame enter in raster order on the input channel
// (i_in_valid / o_in_stall / i_pixel). A word is taken at a clock edge where
// i_in_valid is high and o_in_stall is low. The first pixel of every frame is
// the background reference; every later pixel unlike it widens the box.
// After the last pixel of the frame one result word leaves on the output
// channel (o_out_valid / i_out_stall): inclusive bounds, crop size equal to
// right minus left and bottom minus top, and a content flag. A uniform frame
// reports the whole frame with the flag clear.
// Throughput is one pixel per clock cycle while the queue has room. The result
// word is loaded after the last pixel of the frame is taken: the pixel is first
// written into the queue, then popped from its head into the output register.
// If the receiver stalls, the result word holds. Pixels of the next frame keep
// flowing until that frame's last pixel reaches the head of the queue; it waits
// there, the four-entry queue fills behind it and o_in_stall then rises.
// Write frame width and height on the configuration port (index 0 and 1) only
// while idle; not enforced. Reset restores 640 by 480 and starts a new frame.
// ----------------------------------------------------------------------------
module autocrop_bounding_box (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [acb_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [acb_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [acb_pkg::COORD_W-1:0]   o_box_left,
    output logic [acb_pkg::COORD_W-1:0]   o_box_top,
    output logic [acb_pkg::COORD_W-1:0]   o_box_right,
    output logic [acb_pkg::COORD_W-1:0]   o_box_bottom,
    output logic [acb_pkg::COORD_W-1:0]   o_crop_width,
    output logic [acb_pkg::COORD_W-1:0]   o_crop_height,
    output logic                          o_content_found
);
    import acb_pkg::*;

    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    t_frame_size       size;
    t_entry            front_entry;
    t_entry            head_entry;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              accept;

    // Configuration registers, stored as written and clamped on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign size.width  = clamp_size(r_frame_width, SIZE_W'(MAX_WIDTH));
    assign size.height = clamp_size(r_frame_height, SIZE_W'(MAX_HEIGHT));

    // The front writes straight into the queue, so a pixel is taken whenever
    // the queue has room.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    acb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (size),
        .i_valid  (i_in_valid),
        .i_pixel  (i_pixel),
        .i_accept (accept),
        .o_entry  (front_entry)
    );

    acb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    acb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_size          (size),
        .i_q_valid       (q_valid),
        .i_entry         (head_entry),
        .o_pop           (q_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_right     (o_box_right),
        .o_box_bottom    (o_box_bottom),
        .o_crop_width    (o_crop_width),
        .o_crop_height   (o_crop_height),
        .o_content_found (o_content_found)
    );

endmodule

/* sv/acb_front.sv */
// ----------------------------------------------------------------------------
// acb_front
// Tracks the raster position, latches the reference pixel and classifies each
// accepted pixel as matching or differing.
// ----------------------------------------------------------------------------
module acb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acb_pkg::t_frame_size          i_size,
    input  logic                          i_valid,
    input  logic [acb_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic                          i_accept,
    output acb_pkg::t_entry               o_entry
);
    import acb_pkg::*;

    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [PIXEL_W-1:0] r_ref;
    logic               at_origin;
    logic               row_end;
    logic               frame_end;

    assign at_origin = (r_col == '0) && (r_row == '0);
    assign row_end   = ({1'b0, r_col} + SIZE_W'(1)) >= i_size.width;
    assign frame_end = row_end && (({1'b0, r_row} + SIZE_W'(1)) >= i_size.height);

    always_comb begin
        o_entry.col  = r_col;
        o_entry.row  = r_row;
        o_entry.diff = !at_origin && (i_pixel != r_ref) && i_valid;
        o_entry.last = frame_end;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!row_end) begin
            n_col = r_col + COORD_W'(1);
        end else if (!frame_end) begin
            n_col = '0;
            n_row = r_row + COORD_W'(1);
        end else begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && at_origin) begin
            r_ref <= i_pixel;
        end
    end

endmodule

/* sv/acb_queue.sv */
// ----------------------------------------------------------------------------
// acb_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module acb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acb_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output acb_pkg::t_entry o_entry
);
    import acb_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* sv/acb_back.sv */
// ----------------------------------------------------------------------------
// acb_back
// Accumulates the bounding box from classified pixels and holds the result
// word in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module acb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acb_pkg::t_frame_size         i_size,
    input  logic                         i_q_valid,
    input  acb_pkg::t_entry              i_entry,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [acb_pkg::COORD_W-1:0]  o_box_left,
    output logic [acb_pkg::COORD_W-1:0]  o_box_top,
    output logic [acb_pkg::COORD_W-1:0]  o_box_right,
    output logic [acb_pkg::COORD_W-1:0]  o_box_bottom,
    output logic [acb_pkg::COORD_W-1:0]  o_crop_width,
    output logic [acb_pkg::COORD_W-1:0]  o_crop_height,
    output logic                         o_content_found
);
    import acb_pkg::*;

    logic               r_seen, n_seen;
    logic [COORD_W-1:0] r_min_col, n_min_col;
    logic [COORD_W-1:0] r_max_col, n_max_col;
    logic [COORD_W-1:0] r_min_row, n_min_row;
    logic [COORD_W-1:0] r_max_row, n_max_row;
    logic               r_out_valid;
    logic               slot_free;
    logic [COORD_W-1:0] left, top, right, bottom;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_pop     = i_q_valid && (!i_entry.last || slot_free);
    assign o_valid   = r_out_valid;

    // Running extremes including the pixel at the head of the queue.
    always_comb begin
        n_seen    = r_seen;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (i_entry.diff) begin
            n_seen = 1'b1;
            if (!r_seen || i_entry.col < r_min_col) n_min_col = i_entry.col;
            if (!r_seen || i_entry.col > r_max_col) n_max_col = i_entry.col;
            if (!r_seen || i_entry.row < r_min_row) n_min_row = i_entry.row;
            if (!r_seen || i_entry.row > r_max_row) n_max_row = i_entry.row;
        end
    end

    always_comb begin
        if (n_seen) begin
            left   = n_min_col;
            top    = n_min_row;
            right  = n_max_col;
            bottom = n_max_row;
        end else begin
            left   = '0;
            top    = '0;
            right  = COORD_W'(i_size.width - SIZE_W'(1));
            bottom = COORD_W'(i_size.height - SIZE_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seen <= i_entry.last ? 1'b0 : n_seen;
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
        end
        if (o_pop && i_entry.last) begin
            o_box_left      <= left;
            o_box_top       <= top;
            o_box_right     <= right;
            o_box_bottom    <= bottom;
            o_crop_width    <= right - left;
            o_crop_height   <= bottom - top;
            o_content_found <= n_seen;
        end
    end

endmodule

/* sv/acb_checker.sv */
// ----------------------------------------------------------------------------
// acb_checker
// Port-level assertions on the result word of the autocrop block.
// ----------------------------------------------------------------------------
`include "autocrop_bounding_box_assert.svh"

module acb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [acb_pkg::COORD_W-1:0]   o_box_left,
    input logic [acb_pkg::COORD_W-1:0]   o_box_top,
    input logic [acb_pkg::COORD_W-1:0]   o_box_right,
    input logic [acb_pkg::COORD_W-1:0]   o_box_bottom,
    input logic [acb_pkg::COORD_W-1:0]   o_crop_width,
    input logic [acb_pkg::COORD_W-1:0]   o_crop_height,
    input logic                          o_content_found
);
    import acb_pkg::*;

    // A stalled result word stays and keeps its left and right bounds and its crop width.
    `ACB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_box_left) && $stable(o_box_right) && $stable(o_crop_width), "result word changed while stalled")

    // The crop size follows the bounds.
    `ACB_ASSERT_NOW(a_crop, i_clk, i_rst_n, o_out_valid, (o_crop_width == COORD_W'(o_box_right - o_box_left)) && (o_crop_height == COORD_W'(o_box_bottom - o_box_top)), "crop size does not match bounds")

    // A uniform frame reports a box anchored at the origin.
    `ACB_ASSERT_NOW(a_uniform, i_clk, i_rst_n, o_out_valid && !o_content_found, (o_box_left == '0) && (o_box_top == '0), "uniform frame not anchored at origin")

    // Found content gives ordered bounds.
    `ACB_ASSERT_NOW(a_order, i_clk, i_rst_n, o_out_valid && o_content_found, (o_box_left <= o_box_right) && (o_box_top <= o_box_bottom), "bounds out of order")

endmodule

bind autocrop_bounding_box acb_checker u_acb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_box_left      (o_box_left),
    .o_box_top       (o_box_top),
    .o_box_right     (o_box_right),
    .o_box_bottom    (o_box_bottom),
    .o_crop_width    (o_crop_width),
    .o_crop_height   (o_crop_height),
    .o_content_found (o_content_found)
);

/* tb/autocrop_bounding_box_test.sv */
// ----------------------------------------------------------------------------
// autocrop_bounding_box_test
// Self-checking regression for the autocrop bounding box block.
// ----------------------------------------------------------------------------
// Whole frames are fed in, and each crop result is compared with the box that
// the testbench works out for itself. Small directed frames come first. Then a
// frame has its size rewritten part way through, starting from an over-range
// width and a zero height, and long single-row and single-column frames follow.
// Random phases then pick a new frame size and a new idling pattern, and send
// frames of several kinds: uniform, rectangle, scattered points and noise.
// ----------------------------------------------------------------------------
module autocrop_bounding_box_test;

    // Frame contents that the stimulus can build.
    typedef enum int {
        FRAME_UNIFORM,
        FRAME_RECT,
        FRAME_SPARSE,
        FRAME_NOISE
    } t_frame_kind;

    // Handshake pressure for one phase of the run.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One crop result word, in the order of the output ports.
    typedef struct packed {
        logic [acb_pkg::COORD_W-1:0] box_left;
        logic [acb_pkg::COORD_W-1:0] box_top;
        logic [acb_pkg::COORD_W-1:0] box_right;
        logic [acb_pkg::COORD_W-1:0] box_bottom;
        logic [acb_pkg::COORD_W-1:0] crop_width;
        logic [acb_pkg::COORD_W-1:0] crop_height;
        logic                        content_found;
    } t_crop_box;

    // Every input has a known value from time zero.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = acb_pkg::CFG_FRAME_WIDTH;
    logic [acb_pkg::SIZE_W-1:0]    i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic [acb_pkg::PIXEL_W-1:0]   i_pixel = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [acb_pkg::COORD_W-1:0]   o_box_left;
    logic [acb_pkg::COORD_W-1:0]   o_box_top;
    logic [acb_pkg::COORD_W-1:0]   o_box_right;
    logic [acb_pkg::COORD_W-1:0]   o_box_bottom;
    logic [acb_pkg::COORD_W-1:0]   o_crop_width;
    logic [acb_pkg::COORD_W-1:0]   o_crop_height;
    logic                          o_content_found;

    // Pixels waiting to be sent, and crop results still owed by the block.
    logic [acb_pkg::PIXEL_W-1:0]   pixel_backlog[$];
    t_crop_box                     expected_boxes[$];

    // Idling odds, in percent, for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    // The testbench's own copy of the frame size registers.
    logic [acb_pkg::SIZE_W-1:0]    width_reg = acb_pkg::RESET_WIDTH;
    logic [acb_pkg::SIZE_W-1:0]    height_reg = acb_pkg::RESET_HEIGHT;

    // Scan position and bounding box of the frame in flight.
    int unsigned                   pos_col = 0;
    int unsigned                   pos_row = 0;
    logic [acb_pkg::PIXEL_W-1:0]   bg_pixel = '0;
    int unsigned                   lo_col = 32'hFFFF_FFFF;
    int unsigned                   hi_col = 0;
    int unsigned                   lo_row = 32'hFFFF_FFFF;
    int unsigned                   hi_row = 0;
    bit                            any_diff = 1'b0;

    int unsigned pixels_accepted = 0;
    int unsigned boxes_checked = 0;
    int unsigned phase_count = 0;
    int unsigned error_count = 0;

    autocrop_bounding_box u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_right     (o_box_right),
        .o_box_bottom    (o_box_bottom),
        .o_crop_width    (o_crop_width),
        .o_crop_height   (o_crop_height),
        .o_content_found (o_content_found)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // A size register of zero acts as one, and anything past the limit acts as
    // the limit.
    function automatic int unsigned effective_size(input logic [acb_pkg::SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        if (v > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Advances the scan by one accepted pixel. At the last pixel of the frame
    // the crop result is queued and the scan starts afresh.
    task automatic crop_predict_pixel(input logic [acb_pkg::PIXEL_W-1:0] px);
        int unsigned w;
        int unsigned h;
        t_crop_box   box;
        w = effective_size(width_reg, acb_pkg::MAX_WIDTH);
        h = effective_size(height_reg, acb_pkg::MAX_HEIGHT);
        pixels_accepted++;
        // The first pixel of every frame becomes the background.
        if (pos_col == 0 && pos_row == 0) begin
            bg_pixel = px;
        end
        if (px != bg_pixel) begin
            if (pos_col < lo_col) lo_col = pos_col;
            if (pos_col > hi_col) hi_col = pos_col;
            if (pos_row < lo_row) lo_row = pos_row;
            if (pos_row > hi_row) hi_row = pos_row;
            any_diff = 1'b1;
        end
        if (pos_col + 1 < w) begin
            pos_col++;
        end else if (pos_row + 1 < h) begin
            pos_col = 0;
            pos_row++;
        end else begin
            // A frame with nothing in it reports the whole frame.
            if (any_diff) begin
                box.box_left   = acb_pkg::COORD_W'(lo_col);
                box.box_top    = acb_pkg::COORD_W'(lo_row);
                box.box_right  = acb_pkg::COORD_W'(hi_col);
                box.box_bottom = acb_pkg::COORD_W'(hi_row);
            end else begin
                box.box_left   = '0;
                box.box_top    = '0;
                box.box_right  = acb_pkg::COORD_W'(w - 1);
                box.box_bottom = acb_pkg::COORD_W'(h - 1);
            end
            // The crop size keeps the one-pixel shrink: no plus one here.
            box.crop_width    = box.box_right - box.box_left;
            box.crop_height   = box.box_bottom - box.box_top;
            box.content_found = any_diff;
            expected_boxes.push_back(box);
            pos_col  = 0;
            pos_row  = 0;
            bg_pixel = '0;
            lo_col   = 32'hFFFF_FFFF;
            hi_col   = 0;
            lo_row   = 32'hFFFF_FFFF;
            hi_row   = 0;
            any_diff = 1'b0;
        end
    endtask

    // Compares one accepted result word with the oldest expectation.
    task automatic check_crop_box();
        t_crop_box got;
        t_crop_box want;
        got = {o_box_left, o_box_top, o_box_right, o_box_bottom,
               o_crop_width, o_crop_height, o_content_found};
        boxes_checked++;
        if (expected_boxes.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("unexpected crop word: L%0d T%0d R%0d B%0d W%0d H%0d F%0b",
                         got.box_left, got.box_top, got.box_right, got.box_bottom,
                         got.crop_width, got.crop_height, got.content_found);
            end
        end else begin
            want = expected_boxes.pop_front();
            if (got.box_left !== want.box_left || got.box_top !== want.box_top ||
                got.box_right !== want.box_right || got.box_bottom !== want.box_bottom ||
                got.crop_width !== want.crop_width ||
                got.crop_height !== want.crop_height ||
                got.content_found !== want.content_found) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("crop word %0d: expected L%0d T%0d R%0d B%0d W%0d H%0d F%0b",
                             boxes_checked, want.box_left, want.box_top, want.box_right,
                             want.box_bottom, want.crop_width, want.crop_height,
                             want.content_found);
                    $display("crop word %0d: got      L%0d T%0d R%0d B%0d W%0d H%0d F%0b",
                             boxes_checked, got.box_left, got.box_top, got.box_right,
                             got.box_bottom, got.crop_width, got.crop_height,
                             got.content_found);
                end
            end
        end
    endtask

    // Sender. A word that is offered stays put until it is taken; only then,
    // or while the channel is empty, may the next one be chosen or a gap left.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                crop_predict_pixel(i_pixel);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pixel_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_pixel    <= pixel_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Stall is drawn afresh every cycle, whether or not a word is
    // waiting, so that it lands on every phase of the output register.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_crop_box();
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hard stop. The slowest legal run is well under a tenth of this.
    initial begin
        #12_000_000;
        $display("autocrop_bounding_box regression: fail");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        t_idle_mode mode;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: the smallest sizes, clamped zero sizes, uniform
        // frames, a difference only at the last pixel, a single-bit difference
        // and a difference down a one-pixel column.
        set_idling(IDLE_NONE);
        reconfigure(1, 1);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        reconfigure(0, 0);
        pixel_backlog.push_back(32'h0000_0000);
        reconfigure(3, 2);
        repeat (6) pixel_backlog.push_back(32'h1234_5678);
        repeat (5) pixel_backlog.push_back(32'h0000_0000);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        reconfigure(2, 2);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        pixel_backlog.push_back(32'hFFFF_FFFE);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        reconfigure(1, 3);
        pixel_backlog.push_back(32'h0000_0000);
        pixel_backlog.push_back(32'h8000_0000);
        pixel_backlog.push_back(32'h0000_0000);

        // Size rewritten part way through a frame: a long row at the clamped
        // width is cut short by a narrower width, and the next pixel then
        // closes the frame.
        set_idling(IDLE_BOTH);
        reconfigure(8191, 0);
        for (int i = 0; i < 40; i++) begin
            pixel_backlog.push_back((i % 7 == 3) ? 32'h00C0_FFEE : 32'h0000_0000);
        end
        reconfigure(3, 1);
        pixel_backlog.push_back(32'h0000_0001);

        // Long single-row and single-column frames.
        set_idling(IDLE_NONE);
        reconfigure(24, 1);
        queue_frame(FRAME_RECT);
        set_idling(IDLE_RECEIVER);
        reconfigure(1, 24);
        queue_frame(FRAME_SPARSE);

        // Random phases, each with a fresh size and idling pattern.
        while (pixels_accepted < 950) begin
            mode = t_idle_mode'(phase_count % 4);
            set_idling(mode);
            reconfigure(pick_size(), pick_size());
            repeat ($urandom_range(1, 4)) queue_frame(pick_kind());
            phase_count++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("checked %0d crop words from %0d pixels over %0d random phases",
                 boxes_checked, pixels_accepted, phase_count);
        $display("%0d mismatches or stray words", error_count);
        if (error_count == 0 && expected_boxes.size() == 0) begin
            $display("autocrop_bounding_box regression: pass");
        end else begin
            $display("autocrop_bounding_box regression: fail");
        end
        $finish;
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 72;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 72;
            end
            default: begin
                send_idle_pct = 22;
                stall_pct     = 22;
            end
        endcase
    endtask

    // Waits until every pixel has gone in and every result has come out. It
    // samples on the falling edge so that it never races the sender's queue
    // pop, then lets anything still in the pipeline settle.
    task automatic drain();
        while (pixel_backlog.size() != 0 || i_in_valid || expected_boxes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Writes both size registers once the block has gone quiet.
    task automatic reconfigure(input int unsigned w, input int unsigned h);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= acb_pkg::CFG_FRAME_WIDTH;
        i_cfg_data  <= acb_pkg::SIZE_W'(w);
        width_reg   = acb_pkg::SIZE_W'(w);
        @(posedge i_clk);
        i_cfg_index <= acb_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data  <= acb_pkg::SIZE_W'(h);
        height_reg  = acb_pkg::SIZE_W'(h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly small frames so that results come often; now and then a zero,
    // and rarely a mid-sized one.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 8);
        if (r < 92) return $urandom_range(9, 16);
        if (r < 96) return 0;
        return $urandom_range(17, 24);
    endfunction

    function automatic t_frame_kind pick_kind();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return FRAME_UNIFORM;
        if (r == 1) return FRAME_NOISE;
        if (r < 4) return FRAME_SPARSE;
        return FRAME_RECT;
    endfunction

    // A foreground pixel: either a one-bit change of the background, to
    // exercise each bit of the comparison, or any value at all.
    function automatic logic [acb_pkg::PIXEL_W-1:0] contrast_pixel(
        input logic [acb_pkg::PIXEL_W-1:0] bg);
        if ($urandom_range(1) == 0) begin
            return bg ^ (32'h1 << $urandom_range(31));
        end
        return $urandom;
    endfunction

    // Queues one whole frame at the current effective size.
    task automatic queue_frame(input t_frame_kind kind);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 c0;
        int unsigned                 c1;
        int unsigned                 r0;
        int unsigned                 r1;
        int unsigned                 tmp;
        logic [acb_pkg::PIXEL_W-1:0] bg;
        logic [acb_pkg::PIXEL_W-1:0] px;
        w = effective_size(width_reg, acb_pkg::MAX_WIDTH);
        h = effective_size(height_reg, acb_pkg::MAX_HEIGHT);
        case ($urandom_range(3))
            0:       bg = '0;
            1:       bg = '1;
            default: bg = $urandom;
        endcase
        c0 = $urandom_range(w - 1);
        c1 = $urandom_range(w - 1);
        r0 = $urandom_range(h - 1);
        r1 = $urandom_range(h - 1);
        if (c1 < c0) begin
            tmp = c0;
            c0  = c1;
            c1  = tmp;
        end
        if (r1 < r0) begin
            tmp = r0;
            r0  = r1;
            r1  = tmp;
        end
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                case (kind)
                    FRAME_UNIFORM: px = bg;
                    FRAME_RECT: begin
                        if (c >= c0 && c <= c1 && r >= r0 && r <= r1) begin
                            px = contrast_pixel(bg);
                        end else begin
                            px = bg;
                        end
                    end
                    FRAME_SPARSE: px = ($urandom_range(31) == 0) ? contrast_pixel(bg) : bg;
                    default:      px = $urandom;
                endcase
                pixel_backlog.push_back(px);
            end
        end
    endtask

endmodule
